// File: sv/hts_pkg.sv
package hts_pkg;

    localparam int MAX_NAME    = 6;
    localparam int NAME_LEN_W  = $clog2(MAX_NAME + 1);
    localparam int NAME_IDX_W  = $clog2(MAX_NAME);

    localparam int MAX_RESULTS = 3;
    localparam int BURST_CNT_W = $clog2(MAX_RESULTS + 1);

    localparam int OBUF_DEPTH  = 4;
    localparam int OBUF_PTR_W  = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W  = $clog2(OBUF_DEPTH + 1);

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;

    localparam logic [7:0]  TAG_P     = "P";
    localparam logic [15:0] TAG_BR    = "BR";
    localparam logic [47:0] TAG_TITLE = "/TITLE";

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_item;
        logic       ended_in_tag;
    } hts_res_t;

    typedef struct packed {
        logic [BURST_CNT_W-1:0]         n;
        hts_res_t [MAX_RESULTS-1:0]     res;
    } hts_burst_t;

endpackage

// File: sv/hts_scan.sv
module hts_scan
    import hts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] ch,
    input  logic       eot,
    output hts_burst_t burst
);

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_WS   = 2'd1;
    localparam logic [1:0] MODE_NAME = 2'd2;
    localparam logic [1:0] MODE_SKIP = 2'd3;

    logic [1:0]            mode_reg, mode_next;
    logic [NAME_LEN_W-1:0] len_reg, len_next;
    logic                  ovf_reg, ovf_next;
    logic [7:0]            name_reg [MAX_NAME];
    logic                  store;
    logic                  is_ws, is_gt;
    logic                  emit_ch, emit_nl;
    logic                  match_p, match_br, match_title;
    logic [7:0]            up [MAX_NAME];
    logic [1:0]            mode_tag;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < MAX_NAME; i++)
        begin
            up[i] = upcase(name_reg[i]);
        end
    end

    assign is_ws = (ch == CH_SP) || (ch >= CH_TAB && ch <= CH_CR);
    assign is_gt = (ch == CH_GT);

    assign match_p  = !ovf_reg && (len_reg == NAME_LEN_W'(1)) && (up[0] == TAG_P);
    assign match_br = !ovf_reg && (len_reg == NAME_LEN_W'(2))
                      && (up[0] == TAG_BR[15:8]) && (up[1] == TAG_BR[7:0]);

    always_comb
    begin
        match_title = !ovf_reg && (len_reg == NAME_LEN_W'(6));
        for (int i = 0; i < 6; i++)
        begin
            if (up[i] != TAG_TITLE[8*(5-i) +: 8])
            begin
                match_title = 1'b0;
            end
        end
    end

    always_comb
    begin
        mode_tag = mode_reg;
        len_next = len_reg;
        ovf_next = ovf_reg;
        store    = 1'b0;
        emit_ch  = 1'b0;
        emit_nl  = 1'b0;
        case (mode_reg)
            MODE_TEXT:
            begin
                if (ch == CH_LT)
                begin
                    mode_tag = MODE_WS;
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                else if (ch != CH_CR && ch != CH_LF && ch != CH_NUL)
                begin
                    emit_ch = 1'b1;
                end
            end
            MODE_WS, MODE_NAME:
            begin
                if (mode_reg == MODE_WS && is_ws)
                begin
                    mode_tag = MODE_WS;
                end
                else if (is_ws || is_gt)
                begin
                    emit_nl  = match_p || match_br || match_title;
                    mode_tag = is_gt ? MODE_TEXT : MODE_SKIP;
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                else
                begin
                    mode_tag = MODE_NAME;
                    if (len_reg < NAME_LEN_W'(MAX_NAME))
                    begin
                        store    = 1'b1;
                        len_next = len_reg + NAME_LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            default:
            begin
                if (is_gt)
                begin
                    mode_tag = MODE_TEXT;
                end
            end
        endcase
    end

    // assemble the burst of results and drop back to text mode at end of text
    always_comb
    begin
        burst     = '0;
        mode_next = mode_tag;
        if (emit_ch)
        begin
            burst.res[0] = '{out_char: ch, last_item: 1'b0, ended_in_tag: 1'b0};
            burst.n      = BURST_CNT_W'(1);
        end
        if (emit_nl)
        begin
            burst.res[0] = '{out_char: CH_LF, last_item: 1'b0, ended_in_tag: 1'b0};
            burst.res[1] = '{out_char: CH_LF, last_item: 1'b0, ended_in_tag: 1'b0};
            burst.n      = BURST_CNT_W'(2);
        end
        if (eot)
        begin
            burst.res[burst.n] = '{out_char: CH_NUL, last_item: 1'b1,
                                   ended_in_tag: (mode_tag != MODE_TEXT)};
            burst.n   = burst.n + BURST_CNT_W'(1);
            mode_next = MODE_TEXT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            len_reg  <= eot ? '0 : len_next;
            ovf_reg  <= eot ? 1'b0 : ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && store)
        begin
            name_reg[len_reg[NAME_IDX_W-1:0]] <= ch;
        end
    end

endmodule

// File: sv/hts_obuf.sv
module hts_obuf
    import hts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hts_burst_t push,
    input  logic       pop,
    output logic       room,
    output logic       head_valid,
    output hts_res_t   head
);

    hts_res_t              entry_reg [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OBUF_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OBUF_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OBUF_CNT_W-1:0] cnt_after_pop;

    assign head_valid    = (cnt_reg != '0);
    assign head          = entry_reg[rd_ptr_reg];
    assign cnt_after_pop = cnt_reg - OBUF_CNT_W'(pop);
    assign room          = (cnt_after_pop <= OBUF_CNT_W'(OBUF_DEPTH - MAX_RESULTS));

    assign wr_ptr_next = wr_ptr_reg + OBUF_PTR_W'(push.n);
    assign rd_ptr_next = rd_ptr_reg + OBUF_PTR_W'(pop);
    assign cnt_next    = cnt_after_pop + OBUF_CNT_W'(push.n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (BURST_CNT_W'(k) < push.n)
            begin
                entry_reg[wr_ptr_reg + OBUF_PTR_W'(k)] <= push.res[k];
            end
        end
    end

endmodule

// File: sv/html_tag_stripper.sv
// Markup tag stripper: one text byte per beat in, zero to three result bytes out.
// Input channel: in_valid / in_stall with ch and end_of_text. Output channel:
// out_valid / out_stall with out_char, last_item and ended_in_tag.
// A beat is taken into an input register, scanned against the tag state once the
// buffer has room, and its results are pushed into a four-entry output buffer whose
// head drives the output ports. With the buffer empty, an accepted beat passes the
// input register and then the buffer before its first result is on the output ports.
// Throughput is one input beat per cycle while the receiver keeps up. A beat
// is scanned only when the buffer can take three results after this cycle's
// pop, so a paragraph or line break (two newlines) or a terminator behind a byte
// fills the buffer faster than it drains, and the input stalls until it drains.
// End of text emits a NUL terminator with last_item set and ended_in_tag giving
// whether the text stopped inside a tag; the tag state then returns to text mode.
// Stalling the output holds the head beat and backs up through the buffer
// into in_stall; no beat is lost or repeated.
// Reset empties the buffer and input register and returns to text mode.
module html_tag_stripper
    import hts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       last_item,
    output logic       ended_in_tag
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] ch_reg;
    logic       eot_reg;
    logic       accept;
    logic       fire;
    logic       room;
    logic       pop;
    hts_burst_t burst;
    hts_burst_t push;
    hts_res_t   head;

    assign fire     = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    assign in_vld_next = accept ? 1'b1 : (fire ? 1'b0 : in_vld_reg);

    always_comb
    begin
        push = burst;
        if (!fire)
        begin
            push.n = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= ch;
            eot_reg <= end_of_text;
        end
    end

    hts_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (ch_reg),
        .eot   (eot_reg),
        .burst (burst)
    );

    hts_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign out_char     = head.out_char;
    assign last_item    = head.last_item;
    assign ended_in_tag = head.ended_in_tag;

endmodule
